[src/wspc_pkg.sv]
// ----------------------------------------------------------------------------
// wspc_pkg
// Widths, register codes, shared types and rounding helpers of the wall
// segment projector.
// ----------------------------------------------------------------------------
package wspc_pkg;

  localparam int CRD_W     = 24;  // world coordinates and heights, Q8
  localparam int DT_W      = 25;  // coordinate minus camera
  localparam int T_W       = 17;  // translated, whole units
  localparam int TRIG_W    = 16;  // sine / cosine, Q14
  localparam int PRD_W     = 33;  // rotation products
  localparam int RS_W      = 34;  // rotation sums
  localparam int R_W       = 20;  // camera space x and depth
  localparam int PIT_W     = 16;  // pitch factor
  localparam int PP_W      = 36;  // pitch times depth
  localparam int HS_W      = 37;  // corner height sum
  localparam int H_W       = 24;  // corner heights
  localparam int CC_W      = 11;  // screen centre
  localparam int OUT_W     = 16;  // screen coordinates
  localparam int CP_W      = 44;  // clip products
  localparam int CN_W      = 45;  // clip numerator
  localparam int CD_W      = 21;  // clip denominator
  localparam int PN_W      = 33;  // projection numerator
  localparam int PD_W      = 20;  // projection denominator
  localparam int CFG_IDX_W = 3;
  localparam int FOCAL     = 200;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CAM_X,
    REG_CAM_Y,
    REG_CAM_Z,
    REG_PITCH,
    REG_SINE,
    REG_COSINE,
    REG_CCOL,
    REG_CROW
  } reg_idx_e;

  typedef struct packed {
    logic signed [CRD_W-1:0]  cam_x;
    logic signed [CRD_W-1:0]  cam_y;
    logic signed [CRD_W-1:0]  cam_z;
    logic signed [PIT_W-1:0]  pitch;
    logic signed [TRIG_W-1:0] sine;
    logic signed [TRIG_W-1:0] cosine;
    logic [CC_W-1:0]          ccol;
    logic [CC_W-1:0]          crow;
  } wspc_cfg_t;

  // Camera space segment: x, depth and two corner heights per endpoint.
  typedef struct packed {
    logic signed [R_W-1:0] x0;
    logic signed [R_W-1:0] x1;
    logic signed [R_W-1:0] y0;
    logic signed [R_W-1:0] y1;
    logic signed [H_W-1:0] b0;
    logic signed [H_W-1:0] b1;
    logic signed [H_W-1:0] t0;
    logic signed [H_W-1:0] t1;
  } wspc_seg_t;

  typedef struct packed {
    logic                    visible;
    logic signed [OUT_W-1:0] col_left;
    logic signed [OUT_W-1:0] col_right;
    logic signed [OUT_W-1:0] bottom_left;
    logic signed [OUT_W-1:0] bottom_right;
    logic signed [OUT_W-1:0] top_left;
    logic signed [OUT_W-1:0] top_right;
  } wspc_res_t;

  localparam logic signed [PN_W-1:0] SAT_HI = PN_W'(32767);
  localparam logic signed [PN_W-1:0] SAT_LO = -PN_W'(32768);

  // Truncating divide by 256.
  function automatic logic signed [T_W-1:0] tdiv256(input logic signed [DT_W-1:0] d);
    logic signed [DT_W-1:0] a;
    a = d + $signed({{(DT_W-8){1'b0}}, {8{d[DT_W-1]}}});
    return T_W'(a >>> 8);
  endfunction

  // Truncating divide by 16384.
  function automatic logic signed [R_W-1:0] rdiv14(input logic signed [RS_W-1:0] s);
    logic signed [RS_W-1:0] a;
    a = s + $signed({{(RS_W-14){1'b0}}, {14{s[RS_W-1]}}});
    return R_W'(a >>> 14);
  endfunction

  // Truncating divide by 8192.
  function automatic logic signed [H_W-1:0] hdiv13(input logic signed [HS_W-1:0] s);
    logic signed [HS_W-1:0] a;
    a = s + $signed({{(HS_W-13){1'b0}}, {13{s[HS_W-1]}}});
    return H_W'(a >>> 13);
  endfunction

  function automatic logic signed [OUT_W-1:0] sat16(input logic signed [PN_W-1:0] v);
    logic signed [PN_W-1:0] c;
    if (v > SAT_HI) begin
      c = SAT_HI;
    end else if (v < SAT_LO) begin
      c = SAT_LO;
    end else begin
      c = v;
    end
    return OUT_W'(c);
  endfunction

endpackage

[src/wspc_div.sv]
// ----------------------------------------------------------------------------
// wspc_div
// Pipelined restoring divider, one quotient bit per stage, several lanes.
// Signed numerator, positive denominator, quotient truncated toward zero.
// Stages: take magnitudes, one per quotient bit, restore sign; all hold while en_i is low.
// ----------------------------------------------------------------------------
module wspc_div #(
  parameter int LANES  = 1,
  parameter int NUM_W  = 8,
  parameter int DEN_W  = 4,
  parameter int SIDE_W = 1
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             en_i,
  input  logic                             valid_i,
  input  logic [LANES-1:0][NUM_W-1:0]      num_i,
  input  logic [LANES-1:0][DEN_W-1:0]      den_i,
  input  logic [SIDE_W-1:0]                side_i,
  output logic                             valid_o,
  output logic [LANES-1:0][NUM_W-1:0]      quo_o,
  output logic [SIDE_W-1:0]                side_o
);

  logic [NUM_W:0]                    v_q;
  logic [SIDE_W-1:0]                 side_q [NUM_W+1];
  logic [LANES-1:0]                  neg_q  [NUM_W+1];
  logic [LANES-1:0][DEN_W-1:0]       den_q  [NUM_W+1];
  logic [LANES-1:0][DEN_W-1:0]       rem_q  [NUM_W+1];
  logic [LANES-1:0][NUM_W-1:0]       nq_q   [NUM_W+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q     <= '0;
      valid_o <= 1'b0;
    end else if (en_i) begin
      v_q     <= {v_q[NUM_W-1:0], valid_i};
      valid_o <= v_q[NUM_W];
    end
  end

  // take magnitudes
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_q[0] <= side_i;
      for (int l = 0; l < LANES; l++) begin
        neg_q[0][l] <= num_i[l][NUM_W-1];
        nq_q[0][l]  <= num_i[l][NUM_W-1] ? (~num_i[l] + NUM_W'(1)) : num_i[l];
        rem_q[0][l] <= '0;
        den_q[0][l] <= den_i[l];
      end
    end
  end

  for (genvar k = 0; k < NUM_W; k++) begin : g_step
    logic [LANES-1:0][DEN_W:0] part;
    logic [LANES-1:0][DEN_W:0] trial;

    always_comb begin
      for (int l = 0; l < LANES; l++) begin
        part[l]  = {rem_q[k][l], nq_q[k][l][NUM_W-1]};
        trial[l] = part[l] - {1'b0, den_q[k][l]};
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        side_q[k+1] <= side_q[k];
        neg_q[k+1]  <= neg_q[k];
        den_q[k+1]  <= den_q[k];
        for (int l = 0; l < LANES; l++) begin
          if (!trial[l][DEN_W]) begin
            rem_q[k+1][l] <= trial[l][DEN_W-1:0];
            nq_q[k+1][l]  <= {nq_q[k][l][NUM_W-2:0], 1'b1};
          end else begin
            rem_q[k+1][l] <= part[l][DEN_W-1:0];
            nq_q[k+1][l]  <= {nq_q[k][l][NUM_W-2:0], 1'b0};
          end
        end
      end
    end
  end

  // restore sign
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_o <= side_q[NUM_W];
      for (int l = 0; l < LANES; l++) begin
        quo_o[l] <= neg_q[NUM_W][l] ? (~nq_q[NUM_W][l] + NUM_W'(1)) : nq_q[NUM_W][l];
      end
    end
  end

endmodule

[src/wspc_xform.sv]
// ----------------------------------------------------------------------------
// wspc_xform
// Camera transform: translate, rotate and form the corner heights.
// Five register stages.
// ----------------------------------------------------------------------------
module wspc_xform import wspc_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    en_i,
  input  wspc_cfg_t               cfg_i,
  input  logic                    valid_i,
  input  logic signed [CRD_W-1:0] start_x_i,
  input  logic signed [CRD_W-1:0] start_y_i,
  input  logic signed [CRD_W-1:0] end_x_i,
  input  logic signed [CRD_W-1:0] end_y_i,
  input  logic signed [CRD_W-1:0] floor_height_i,
  input  logic signed [CRD_W-1:0] ceiling_height_i,
  input  logic                    back_face_i,
  output logic                    valid_o,
  output wspc_seg_t               seg_o
);

  logic [4:0] v_q;
  logic signed [T_W-1:0]   ax, ay, bx, by;
  logic signed [T_W-1:0]   tx0_q, ty0_q, tx1_q, ty1_q;
  logic signed [DT_W-1:0]  df_q [4];
  logic signed [DT_W-1:0]  dc_q [4];
  logic signed [PRD_W-1:0] xc0_q, ys0_q, yc0_q, xs0_q;
  logic signed [PRD_W-1:0] xc1_q, ys1_q, yc1_q, xs1_q;
  logic signed [R_W-1:0]   x0_q [2];
  logic signed [R_W-1:0]   x1_q [2];
  logic signed [R_W-1:0]   y0_q [2];
  logic signed [R_W-1:0]   y1_q [2];
  logic signed [PP_W-1:0]  pp0_q, pp1_q;

  always_comb begin
    ax = tdiv256(DT_W'(start_x_i) - DT_W'(cfg_i.cam_x));
    ay = tdiv256(DT_W'(start_y_i) - DT_W'(cfg_i.cam_y));
    bx = tdiv256(DT_W'(end_x_i) - DT_W'(cfg_i.cam_x));
    by = tdiv256(DT_W'(end_y_i) - DT_W'(cfg_i.cam_y));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[3:0], valid_i};
    end
  end

  assign valid_o = v_q[4];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      // translate, swap for the back face
      tx0_q   <= back_face_i ? bx : ax;
      ty0_q   <= back_face_i ? by : ay;
      tx1_q   <= back_face_i ? ax : bx;
      ty1_q   <= back_face_i ? ay : by;
      df_q[0] <= DT_W'(floor_height_i) - DT_W'(cfg_i.cam_z);
      dc_q[0] <= DT_W'(ceiling_height_i) - DT_W'(cfg_i.cam_z);
      for (int s = 1; s < 4; s++) begin
        df_q[s] <= df_q[s-1];
        dc_q[s] <= dc_q[s-1];
      end
      // rotation products
      xc0_q <= PRD_W'(tx0_q) * PRD_W'(cfg_i.cosine);
      ys0_q <= PRD_W'(ty0_q) * PRD_W'(cfg_i.sine);
      yc0_q <= PRD_W'(ty0_q) * PRD_W'(cfg_i.cosine);
      xs0_q <= PRD_W'(tx0_q) * PRD_W'(cfg_i.sine);
      xc1_q <= PRD_W'(tx1_q) * PRD_W'(cfg_i.cosine);
      ys1_q <= PRD_W'(ty1_q) * PRD_W'(cfg_i.sine);
      yc1_q <= PRD_W'(ty1_q) * PRD_W'(cfg_i.cosine);
      xs1_q <= PRD_W'(tx1_q) * PRD_W'(cfg_i.sine);
      // rotation sums
      x0_q[0] <= rdiv14(RS_W'(xc0_q) - RS_W'(ys0_q));
      y0_q[0] <= rdiv14(RS_W'(yc0_q) + RS_W'(xs0_q));
      x1_q[0] <= rdiv14(RS_W'(xc1_q) - RS_W'(ys1_q));
      y1_q[0] <= rdiv14(RS_W'(yc1_q) + RS_W'(xs1_q));
      // pitch terms
      x0_q[1] <= x0_q[0];
      y0_q[1] <= y0_q[0];
      x1_q[1] <= x1_q[0];
      y1_q[1] <= y1_q[0];
      pp0_q   <= PP_W'(cfg_i.pitch) * PP_W'(y0_q[0]);
      pp1_q   <= PP_W'(cfg_i.pitch) * PP_W'(y1_q[0]);
      // corner heights
      seg_o.x0 <= x0_q[1];
      seg_o.x1 <= x1_q[1];
      seg_o.y0 <= y0_q[1];
      seg_o.y1 <= y1_q[1];
      seg_o.b0 <= hdiv13((HS_W'(df_q[3]) <<< 5) - HS_W'(pp0_q));
      seg_o.b1 <= hdiv13((HS_W'(df_q[3]) <<< 5) - HS_W'(pp1_q));
      seg_o.t0 <= hdiv13((HS_W'(dc_q[3]) <<< 5) - HS_W'(pp0_q));
      seg_o.t1 <= hdiv13((HS_W'(dc_q[3]) <<< 5) - HS_W'(pp1_q));
    end
  end

endmodule

[src/wspc_clip.sv]
// ----------------------------------------------------------------------------
// wspc_clip
// Near clip: moves an endpoint at or behind the camera to depth 1, with x and
// heights interpolated at depth 0 toward the other endpoint. Flags fully hidden segments.
// ----------------------------------------------------------------------------
module wspc_clip import wspc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      en_i,
  input  logic      valid_i,
  input  wspc_seg_t seg_i,
  output logic      valid_o,
  output logic      vis_o,
  output wspc_seg_t seg_o
);

  localparam int SIDE_W = $bits(wspc_seg_t) + 2;

  logic                   c0, c1;
  logic signed [R_W-1:0]  ya, yb, xa, xb;
  logic signed [H_W-1:0]  ba, bb, ta, tb;

  logic                   v_q;
  logic                   c0_q, c1_q;
  wspc_seg_t              seg_q;
  logic signed [CP_W-1:0] mxa_q, mxb_q, mba_q, mbb_q, mta_q, mtb_q;
  logic signed [CD_W-1:0] den_q;

  logic [2:0][CN_W-1:0]   num;
  logic [2:0][CD_W-1:0]   den;
  logic [2:0][CN_W-1:0]   quo;
  logic [SIDE_W-1:0]      side_out;
  logic                   dv;
  wspc_seg_t              ds;
  logic                   dc0, dc1;
  wspc_seg_t              seg_d;

  always_comb begin
    c0 = seg_i.y0 <= 0;
    c1 = seg_i.y1 <= 0;
    // A is the endpoint being clipped, B the one it moves toward
    ya = c0 ? seg_i.y0 : seg_i.y1;
    yb = c0 ? seg_i.y1 : seg_i.y0;
    xa = c0 ? seg_i.x0 : seg_i.x1;
    xb = c0 ? seg_i.x1 : seg_i.x0;
    ba = c0 ? seg_i.b0 : seg_i.b1;
    bb = c0 ? seg_i.b1 : seg_i.b0;
    ta = c0 ? seg_i.t0 : seg_i.t1;
    tb = c0 ? seg_i.t1 : seg_i.t0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (en_i) begin
      v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      c0_q  <= c0;
      c1_q  <= c1;
      seg_q <= seg_i;
      mxa_q <= CP_W'(xa) * CP_W'(yb);
      mxb_q <= CP_W'(ya) * CP_W'(xb);
      mba_q <= CP_W'(ba) * CP_W'(yb);
      mbb_q <= CP_W'(ya) * CP_W'(bb);
      mta_q <= CP_W'(ta) * CP_W'(yb);
      mtb_q <= CP_W'(ya) * CP_W'(tb);
      den_q <= CD_W'(yb) - CD_W'(ya);
    end
  end

  always_comb begin
    num[0] = CN_W'(mxa_q) - CN_W'(mxb_q);
    num[1] = CN_W'(mba_q) - CN_W'(mbb_q);
    num[2] = CN_W'(mta_q) - CN_W'(mtb_q);
    for (int l = 0; l < 3; l++) begin
      den[l] = den_q;
    end
  end

  wspc_div #(
    .LANES  (3),
    .NUM_W  (CN_W),
    .DEN_W  (CD_W),
    .SIDE_W (SIDE_W)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en_i),
    .valid_i (v_q),
    .num_i   (num),
    .den_i   (den),
    .side_i  ({seg_q, c0_q, c1_q}),
    .valid_o (dv),
    .quo_o   (quo),
    .side_o  (side_out)
  );

  assign {ds, dc0, dc1} = side_out;

  always_comb begin
    seg_d = ds;
    if (dc0) begin
      seg_d.x0 = R_W'(quo[0]);
      seg_d.b0 = H_W'(quo[1]);
      seg_d.t0 = H_W'(quo[2]);
      seg_d.y0 = R_W'(1);
    end else if (dc1) begin
      seg_d.x1 = R_W'(quo[0]);
      seg_d.b1 = H_W'(quo[1]);
      seg_d.t1 = H_W'(quo[2]);
      seg_d.y1 = R_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (en_i) begin
      valid_o <= dv;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      seg_o <= seg_d;
      vis_o <= !(dc0 && dc1);
    end
  end

endmodule

[src/wspc_proj.sv]
// ----------------------------------------------------------------------------
// wspc_proj
// Perspective divide: screen columns and rows of both endpoints,
// saturated to 16 bits. Hidden segments give all zero.
// ----------------------------------------------------------------------------
module wspc_proj import wspc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      en_i,
  input  wspc_cfg_t cfg_i,
  input  logic      valid_i,
  input  logic      vis_i,
  input  wspc_seg_t seg_i,
  output logic      valid_o,
  output wspc_res_t res_o
);

  // lanes: col left, col right, bottom left, bottom right, top left, top right
  localparam int LN = 6;

  logic signed [H_W-1:0]    val [LN];
  logic signed [R_W-1:0]    dep [LN];
  logic [CC_W-1:0]          ctr [LN];

  logic                     v_q, vis_q;
  logic signed [PN_W-1:0]   fm_q [LN];
  logic signed [PN_W-1:0]   cm_q [LN];
  logic [LN-1:0][PD_W-1:0]  den_q;

  logic [LN-1:0][PN_W-1:0]  num;
  logic [LN-1:0][PN_W-1:0]  quo;
  logic                     dvis;

  always_comb begin
    val[0] = H_W'(seg_i.x0);
    val[1] = H_W'(seg_i.x1);
    val[2] = seg_i.b0;
    val[3] = seg_i.b1;
    val[4] = seg_i.t0;
    val[5] = seg_i.t1;
    for (int l = 0; l < LN; l++) begin
      dep[l] = l[0] ? seg_i.y1 : seg_i.y0;
      ctr[l] = (l < 2) ? cfg_i.ccol : cfg_i.crow;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (en_i) begin
      v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      vis_q <= vis_i;
      for (int l = 0; l < LN; l++) begin
        fm_q[l]  <= PN_W'(val[l]) * PN_W'(FOCAL);
        cm_q[l]  <= PN_W'($signed({1'b0, ctr[l]})) * PN_W'(dep[l]);
        den_q[l] <= PD_W'(dep[l]);
      end
    end
  end

  always_comb begin
    for (int l = 0; l < LN; l++) begin
      num[l] = fm_q[l] + cm_q[l];
    end
  end

  wspc_div #(
    .LANES  (LN),
    .NUM_W  (PN_W),
    .DEN_W  (PD_W),
    .SIDE_W (1)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en_i),
    .valid_i (v_q),
    .num_i   (num),
    .den_i   (den_q),
    .side_i  (vis_q),
    .valid_o (valid_o),
    .quo_o   (quo),
    .side_o  (dvis)
  );

  always_comb begin
    res_o.visible      = dvis;
    res_o.col_left     = dvis ? sat16(quo[0]) : '0;
    res_o.col_right    = dvis ? sat16(quo[1]) : '0;
    res_o.bottom_left  = dvis ? sat16(quo[2]) : '0;
    res_o.bottom_right = dvis ? sat16(quo[3]) : '0;
    res_o.top_left     = dvis ? sat16(quo[4]) : '0;
    res_o.top_right    = dvis ? sat16(quo[5]) : '0;
  end

endmodule

[src/wall_segment_project_clip_core.sv]
// ----------------------------------------------------------------------------
// wall_segment_project_clip_core
// Wall segment camera transform, near clip and perspective projection.
// ----------------------------------------------------------------------------
// One wall segment request is taken every clock and one result leaves every
// clock unless stalled; independent segments stream through a pipeline (5
// transform stages, 49 clip stages around a 45-bit pipelined divider, 36
// projection stages around a 33-bit pipelined divider) into a two-entry
// output buffer. The two long dividers, one quotient bit per stage, set the
// latency. The buffer lets a request in while a finished result waits;
// in_stall_o rises only once both buffer entries are full, and then the
// whole pipeline holds. Camera registers are read live by the transform
// and projection stages, so write them only while no request is in flight.
// ----------------------------------------------------------------------------
module wall_segment_project_clip_core import wspc_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  // configuration writes
  input  logic                    cfg_we_i,
  input  logic [CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [CRD_W-1:0]        cfg_data_i,
  // segment requests
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic signed [CRD_W-1:0] start_x_i,
  input  logic signed [CRD_W-1:0] start_y_i,
  input  logic signed [CRD_W-1:0] end_x_i,
  input  logic signed [CRD_W-1:0] end_y_i,
  input  logic signed [CRD_W-1:0] floor_height_i,
  input  logic signed [CRD_W-1:0] ceiling_height_i,
  input  logic                    back_face_i,
  // results
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic                    visible_o,
  output logic signed [OUT_W-1:0] col_left_o,
  output logic signed [OUT_W-1:0] col_right_o,
  output logic signed [OUT_W-1:0] bottom_left_o,
  output logic signed [OUT_W-1:0] bottom_right_o,
  output logic signed [OUT_W-1:0] top_left_o,
  output logic signed [OUT_W-1:0] top_right_o
);

  localparam logic [1:0] BUF_FULL = 2'd2;

  wspc_cfg_t cfg_q;
  logic      adv;
  logic      xv, cv, pv, cvis;
  wspc_seg_t xseg, cseg;
  wspc_res_t pres;
  logic      push, pop;
  logic [1:0] cnt_q, cnt_d;
  wspc_res_t ent0_q, ent1_q;

  // Camera registers, written by index.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.cam_x  <= '0;
      cfg_q.cam_y  <= '0;
      cfg_q.cam_z  <= '0;
      cfg_q.pitch  <= '0;
      cfg_q.sine   <= '0;
      cfg_q.cosine <= TRIG_W'(16384);
      cfg_q.ccol   <= CC_W'(320);
      cfg_q.crow   <= CC_W'(160);
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_idx_i))
        REG_CAM_X:  cfg_q.cam_x  <= cfg_data_i;
        REG_CAM_Y:  cfg_q.cam_y  <= cfg_data_i;
        REG_CAM_Z:  cfg_q.cam_z  <= cfg_data_i;
        REG_PITCH:  cfg_q.pitch  <= cfg_data_i[PIT_W-1:0];
        REG_SINE:   cfg_q.sine   <= cfg_data_i[TRIG_W-1:0];
        REG_COSINE: cfg_q.cosine <= cfg_data_i[TRIG_W-1:0];
        REG_CCOL:   cfg_q.ccol   <= cfg_data_i[CC_W-1:0];
        REG_CROW:   cfg_q.crow   <= cfg_data_i[CC_W-1:0];
        default: ;
      endcase
    end
  end

  // Advance the whole pipeline while the output buffer has room.
  assign adv        = (cnt_q != BUF_FULL);
  assign in_stall_o = !adv;

  wspc_xform u_xform (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .en_i             (adv),
    .cfg_i            (cfg_q),
    .valid_i          (in_valid_i),
    .start_x_i        (start_x_i),
    .start_y_i        (start_y_i),
    .end_x_i          (end_x_i),
    .end_y_i          (end_y_i),
    .floor_height_i   (floor_height_i),
    .ceiling_height_i (ceiling_height_i),
    .back_face_i      (back_face_i),
    .valid_o          (xv),
    .seg_o            (xseg)
  );

  wspc_clip u_clip (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (xv),
    .seg_i   (xseg),
    .valid_o (cv),
    .vis_o   (cvis),
    .seg_o   (cseg)
  );

  wspc_proj u_proj (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .cfg_i   (cfg_q),
    .valid_i (cv),
    .vis_i   (cvis),
    .seg_i   (cseg),
    .valid_o (pv),
    .res_o   (pres)
  );

  // Two-entry output buffer; entry 0 drives the ports.
  assign push = adv && pv;
  assign pop  = out_valid_o && !out_stall_i;

  always_comb begin
    cnt_d = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      if (cnt_q == BUF_FULL) begin
        ent0_q <= ent1_q;
      end else if (push) begin
        ent0_q <= pres;
      end
    end else if (push) begin
      if (cnt_q == 2'd0) begin
        ent0_q <= pres;
      end else begin
        ent1_q <= pres;
      end
    end
  end

  assign out_valid_o    = (cnt_q != 2'd0);
  assign visible_o      = ent0_q.visible;
  assign col_left_o     = ent0_q.col_left;
  assign col_right_o    = ent0_q.col_right;
  assign bottom_left_o  = ent0_q.bottom_left;
  assign bottom_right_o = ent0_q.bottom_right;
  assign top_left_o     = ent0_q.top_left;
  assign top_right_o    = ent0_q.top_right;

endmodule

[src/wspc_chk.sv]
// ----------------------------------------------------------------------------
// wspc_chk
// Port-level checks of the wall segment projector, bound to the top level.
// ----------------------------------------------------------------------------
module wspc_chk (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_stall_o,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic               visible_o,
  input logic signed [15:0] col_left_o,
  input logic signed [15:0] col_right_o,
  input logic signed [15:0] bottom_left_o,
  input logic signed [15:0] bottom_right_o,
  input logic signed [15:0] top_left_o,
  input logic signed [15:0] top_right_o
);

  // hidden segments report all zero
  a_hidden_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !visible_o |-> col_left_o == 0 && col_right_o == 0 &&
      bottom_left_o == 0 && bottom_right_o == 0 && top_left_o == 0 &&
      top_right_o == 0)
    else $error("hidden segment with nonzero coordinates");

  // the input never stalls while no result is pending
  a_no_idle_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled with empty output");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(visible_o) &&
      $stable(col_left_o) && $stable(col_right_o) && $stable(bottom_left_o) &&
      $stable(bottom_right_o) && $stable(top_left_o) && $stable(top_right_o))
    else $error("stalled result changed");

endmodule

bind wall_segment_project_clip_core wspc_chk u_wspc_chk (.*);

[tb/wall_segment_project_clip_core_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// wall_segment_project_clip_core_tb
// Streams wall segments through the projector under random idling and
// back-pressure, predicts every result in camera-space integer arithmetic
// and checks each whole result against the prediction, in order.
// ----------------------------------------------------------------------------
module wall_segment_project_clip_core_tb;
  import wspc_pkg::*;

  localparam int PIPE_LAT = 120;  // pipeline plus output buffer, with margin

  typedef struct {
    logic signed [CRD_W-1:0] sx, sy, ex, ey, fl, cl;
    logic                    bf;
  } wall_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx = '0;
  logic [CRD_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [CRD_W-1:0] start_x = '0, start_y = '0, end_x = '0, end_y = '0;
  logic signed [CRD_W-1:0] floor_h = '0, ceil_h = '0;
  logic back_face = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  wspc_res_t got;

  wall_segment_project_clip_core dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_data_i      (cfg_data),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .start_x_i       (start_x),
    .start_y_i       (start_y),
    .end_x_i         (end_x),
    .end_y_i         (end_y),
    .floor_height_i  (floor_h),
    .ceiling_height_i(ceil_h),
    .back_face_i     (back_face),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .visible_o       (got.visible),
    .col_left_o      (got.col_left),
    .col_right_o     (got.col_right),
    .bottom_left_o   (got.bottom_left),
    .bottom_right_o  (got.bottom_right),
    .top_left_o      (got.top_left),
    .top_right_o     (got.top_right)
  );

  // Shadow copy of the camera registers, updated on every write.
  wspc_cfg_t cam;
  wspc_res_t pending_rows[$];
  int errors = 0;
  int mismatches = 0;
  bit calm = 1'b0;       // no random idling on either side
  int hold_left = 0;     // receiver hold-off still to run

  initial begin
    forever #10 clk = ~clk;
  end

  // Hard stop in case the block hangs.
  initial begin
    #20ms;
    $display("wall_segment_project_clip_core_tb: done, errors");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Prediction
  // --------------------------------------------------------------------------
  function automatic longint clip_to_plane(longint va, longint ya, longint vb, longint yb);
    return (va * yb - ya * vb) / (yb - ya);
  endfunction

  function automatic longint corner_height(longint hgt, longint depth);
    longint cz, pt;
    cz = cam.cam_z;
    pt = cam.pitch;
    return (32 * (hgt - cz) - pt * depth) / 8192;
  endfunction

  function automatic logic signed [OUT_W-1:0] clamp_screen(longint v);
    if (v > 32767) return 16'sd32767;
    if (v < -32768) return -16'sd32768;
    return OUT_W'(v);
  endfunction

  function automatic wspc_res_t project_wall(wall_t w);
    longint cx, cy, sn, cs, ccol, crow, ax, ay, bx, by, t;
    longint x0, x1, y0, y1, b0, b1, t0, t1;
    wspc_res_t r;
    cx = cam.cam_x;
    cy = cam.cam_y;
    sn = cam.sine;
    cs = cam.cosine;
    ccol = longint'(cam.ccol);
    crow = longint'(cam.crow);
    ax = (longint'(w.sx) - cx) / 256;
    ay = (longint'(w.sy) - cy) / 256;
    bx = (longint'(w.ex) - cx) / 256;
    by = (longint'(w.ey) - cy) / 256;
    if (w.bf) begin
      t = ax; ax = bx; bx = t;
      t = ay; ay = by; by = t;
    end
    x0 = (ax * cs - ay * sn) / 16384;
    x1 = (bx * cs - by * sn) / 16384;
    y0 = (ay * cs + ax * sn) / 16384;
    y1 = (by * cs + bx * sn) / 16384;
    b0 = corner_height(longint'(w.fl), y0);
    b1 = corner_height(longint'(w.fl), y1);
    t0 = corner_height(longint'(w.cl), y0);
    t1 = corner_height(longint'(w.cl), y1);
    r = '0;
    if (y0 <= 0 && y1 <= 0) return r;
    if (y0 <= 0) begin
      x0 = clip_to_plane(x0, y0, x1, y1);
      b0 = clip_to_plane(b0, y0, b1, y1);
      t0 = clip_to_plane(t0, y0, t1, y1);
      y0 = 1;
    end else if (y1 <= 0) begin
      x1 = clip_to_plane(x1, y1, x0, y0);
      b1 = clip_to_plane(b1, y1, b0, y0);
      t1 = clip_to_plane(t1, y1, t0, y0);
      y1 = 1;
    end
    r.visible      = 1'b1;
    r.col_left     = clamp_screen((FOCAL * x0 + ccol * y0) / y0);
    r.col_right    = clamp_screen((FOCAL * x1 + ccol * y1) / y1);
    r.bottom_left  = clamp_screen((FOCAL * b0 + crow * y0) / y0);
    r.bottom_right = clamp_screen((FOCAL * b1 + crow * y1) / y1);
    r.top_left     = clamp_screen((FOCAL * t0 + crow * y0) / y0);
    r.top_right    = clamp_screen((FOCAL * t1 + crow * y1) / y1);
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Result checking: outputs settle after the rising edge, so sample them
  // at the falling edge, where they hold the value the next edge accepts.
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    wspc_res_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_rows.size() == 0) begin
        errors++;
        if (mismatches < 10) $display("unexpected result %p", got);
        mismatches++;
      end else begin
        want = pending_rows.pop_front();
        if (got !== want) begin
          errors++;
          if (mismatches < 10) $display("result mismatch: expected %p, got %p", want, got);
          mismatches++;
        end
      end
    end
  end

  // Receiver: hold off while a hold is armed, else stall at random unless calm.
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (calm) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < 24);
    end
  end

  // --------------------------------------------------------------------------
  // Driving helpers; each starts and ends right after a rising edge.
  // --------------------------------------------------------------------------
  task automatic send_wall(wall_t w);
    bit taken;
    if (!calm && $urandom_range(99) < 24) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    start_x   <= w.sx;
    start_y   <= w.sy;
    end_x     <= w.ex;
    end_y     <= w.ey;
    floor_h   <= w.fl;
    ceil_h    <= w.cl;
    back_face <= w.bf;
    do begin
      @(negedge clk);
      taken = !in_stall;
      @(posedge clk);
    end while (!taken);
    pending_rows.push_back(project_wall(w));
  endtask

  // Drop valid and wait until every expected result is back and the
  // pipeline has emptied.
  task automatic drain;
    int guard;
    in_valid <= 1'b0;
    guard = 0;
    while (pending_rows.size() != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    if (pending_rows.size() != 0) begin
      $display("wall_segment_project_clip_core_tb: done, errors");
      $finish;
    end else begin
      repeat (PIPE_LAT) @(posedge clk);
    end
  endtask

  // Raise the write enable for one edge; the caller drops it afterwards.
  task automatic write_reg(reg_idx_e idx, logic [CRD_W-1:0] value);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= value;
    @(posedge clk);
    case (idx)
      REG_CAM_X:  cam.cam_x  = value;
      REG_CAM_Y:  cam.cam_y  = value;
      REG_CAM_Z:  cam.cam_z  = value;
      REG_PITCH:  cam.pitch  = value[PIT_W-1:0];
      REG_SINE:   cam.sine   = value[TRIG_W-1:0];
      REG_COSINE: cam.cosine = value[TRIG_W-1:0];
      REG_CCOL:   cam.ccol   = value[CC_W-1:0];
      default:    cam.crow   = value[CC_W-1:0];
    endcase
  endtask

  task automatic set_camera(int x, int y, int z, int pt, int sn, int cs, int cc, int cr);
    write_reg(REG_CAM_X, x);
    write_reg(REG_CAM_Y, y);
    write_reg(REG_CAM_Z, z);
    write_reg(REG_PITCH, pt);
    write_reg(REG_SINE, sn);
    write_reg(REG_COSINE, cs);
    write_reg(REG_CCOL, cc);
    write_reg(REG_CROW, cr);
    cfg_we <= 1'b0;
  endtask

  function automatic wall_t make_wall(int sx, int sy, int ex, int ey, int fl, int cl, bit bf);
    wall_t w;
    w.sx = sx; w.sy = sy; w.ex = ex; w.ey = ey; w.fl = fl; w.cl = cl; w.bf = bf;
    return w;
  endfunction

  // Mostly walls within a few hundred units of the camera so that most are
  // visible or clipped; a share spans the whole coordinate range.
  function automatic wall_t random_wall();
    wall_t w;
    int span;
    if ($urandom_range(99) < 15) begin
      w.sx = $urandom; w.sy = $urandom; w.ex = $urandom; w.ey = $urandom;
      w.fl = $urandom; w.cl = $urandom;
    end else begin
      span = ($urandom_range(3) == 0) ? 2000000 : 100000;
      w.sx = cam.cam_x + $signed($urandom_range(2 * span)) - span;
      w.sy = cam.cam_y + $signed($urandom_range(2 * span)) - span;
      w.ex = cam.cam_x + $signed($urandom_range(2 * span)) - span;
      w.ey = cam.cam_y + $signed($urandom_range(2 * span)) - span;
      w.fl = cam.cam_z - $signed($urandom_range(20000));
      w.cl = cam.cam_z + $signed($urandom_range(40000)) - 5000;
    end
    w.bf = $urandom_range(1);
    return w;
  endfunction

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  task automatic test_reset_view;
    // Default camera: in front, back face, behind, each endpoint behind, zero depth, a point.
    send_wall(make_wall(-2560, 12800, 2560, 12800, -4096, 8192, 1'b0));
    send_wall(make_wall(-2560, 12800, 2560, 12800, -4096, 8192, 1'b1));
    send_wall(make_wall(-2560, -12800, 2560, -256, 0, 8192, 1'b0));
    send_wall(make_wall(-2560, -5120, 2560, 12800, -4096, 8192, 1'b0));
    send_wall(make_wall(-2560, 12800, 2560, -5120, -4096, 8192, 1'b0));
    send_wall(make_wall(-2560, 0, 2560, 25600, -4096, 8192, 1'b0));
    send_wall(make_wall(-2560, 25600, 2560, 0, -4096, 8192, 1'b1));
    send_wall(make_wall(0, 256, 0, 256, 0, 0, 1'b0));
    drain();
  endtask

  task automatic test_field_extremes;
    send_wall(make_wall(8388607, 8388607, -8388608, 8388607, -8388608, 8388607, 1'b0));
    send_wall(make_wall(-8388608, -8388608, 8388607, 8388607, 8388607, -8388608, 1'b1));
    send_wall(make_wall(8388607, 256, -8388608, 512, 8388607, 8388607, 1'b0));
    send_wall(make_wall(-8388608, 8388607, -8388608, -8388608, -8388608, -8388608, 1'b1));
    drain();
    // Extreme camera: min position, max pitch, quarter turn, max centres.
    set_camera(-8388608, -8388608, -8388608, 32767, 16384, 0, 2047, 2047);
    send_wall(make_wall(-8000000, 8388607, 8388607, -8388608, 8388607, -8388608, 1'b0));
    send_wall(make_wall(8388607, -8000000, 0, 0, 0, 8388607, 1'b1));
    send_wall(make_wall(-8388608, -8388608, -8388608, -8388608, 0, 0, 1'b0));
    drain();
    set_camera(8388607, 8388607, 8388607, -32768, -16384, -16384, 0, 0);
    send_wall(make_wall(8388607, 8388607, -8388608, -8388608, -8388608, 8388607, 1'b0));
    send_wall(make_wall(-8388608, 0, 0, -8388608, 8388607, -8388608, 1'b1));
    send_wall(make_wall(0, 0, 8388607, 8388607, 0, 0, 1'b0));
    drain();
    // Out-of-range trig bits used as their raw value.
    set_camera(0, 0, 0, 256, 32767, -32768, 320, 160);
    send_wall(make_wall(-256000, 256000, 256000, -256000, -2560, 25600, 1'b0));
    send_wall(make_wall(256000, 256000, -256000, 2560, -2560, 25600, 1'b1));
    drain();
  endtask

  task automatic random_camera;
    if ($urandom_range(3) == 0) begin
      set_camera($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                 $urandom, $urandom);
    end else begin
      set_camera($signed($urandom_range(4000000)) - 2000000,
                 $signed($urandom_range(4000000)) - 2000000,
                 $signed($urandom_range(20000)) - 10000,
                 $signed($urandom_range(1024)) - 512,
                 $signed($urandom_range(32768)) - 16384,
                 $signed($urandom_range(32768)) - 16384,
                 $urandom_range(2047), $urandom_range(2047));
    end
  endtask

  task automatic test_random_views(int phases, int per_phase);
    for (int p = 0; p < phases; p++) begin
      random_camera();
      calm = (p == 2);  // one phase runs with no idling at all
      for (int i = 0; i < per_phase; i++) send_wall(random_wall());
      calm = 1'b0;
      drain();
    end
  endtask

  task automatic test_backpressure;
    // Hold the receiver long enough for the pipeline and buffer to fill
    // while requests keep coming, so the input stalls.
    calm = 1'b1;
    hold_left = 400;
    for (int i = 0; i < 150; i++) send_wall(random_wall());
    calm = 1'b0;
    drain();
  endtask

  initial begin
    cam = '0;
    cam.cosine = 16384;
    cam.ccol = 320;
    cam.crow = 160;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_view();
    test_field_extremes();
    test_random_views(12, 100);
    test_backpressure();
    test_random_views(2, 50);
    if (errors == 0 && pending_rows.size() == 0) begin
      $display("wall_segment_project_clip_core_tb: done, clean");
    end else begin
      $display("wall_segment_project_clip_core_tb: done, errors");
    end
    $finish;
  end

endmodule

[filelist.f]
src/wspc_pkg.sv
src/wspc_div.sv
src/wspc_xform.sv
src/wspc_clip.sv
src/wspc_proj.sv
src/wall_segment_project_clip_core.sv
src/wspc_chk.sv
tb/wall_segment_project_clip_core_tb.sv
